>>> design/scag_pkg.sv
// ----------------------------------------------------------------------------
// scag_pkg
// Shared constants and register codes of the strided concat address generator.
// ----------------------------------------------------------------------------
package scag_pkg;

  localparam int DATA_W         = 32;
  localparam int WORD_W         = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int DIMS_W         = 3;
  localparam int CONCAT_W       = 2;
  localparam int SHIFT_W        = 16;

  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_SIZE_BITS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS_IN_USE  = 3'd0,
    REG_CONCAT_DIM   = 3'd1,
    REG_DIM_SHIFT    = 3'd2,
    REG_SOURCE_BASE  = 3'd3,
    REG_SOURCE_SIZES = 3'd4,
    REG_SOURCE_STEPS = 3'd5,
    REG_DEST_SIZES   = 3'd6
  } cfg_reg_e;

endpackage

>>> design/scag_div_slot.sv
// ----------------------------------------------------------------------------
// scag_div_slot
// Pipelined restoring divider for one dimension: one quotient bit per stage.
// A zero divisor passes the dividend through as quotient with remainder 0.
// ----------------------------------------------------------------------------
module scag_div_slot
  import scag_pkg::*;
#(
  parameter int SIZE_BITS = DEF_SIZE_BITS,
  parameter int SIDE_W    = DATA_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [DATA_W-1:0]    dividend_i,
  input  logic [SIZE_BITS-1:0] divisor_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [DATA_W-1:0]    quotient_o,
  output logic [SIZE_BITS-1:0] remainder_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 v_q    [DATA_W];
  logic [DATA_W-1:0]    work_q [DATA_W];
  logic [SIZE_BITS-1:0] rem_q  [DATA_W];
  logic [SIDE_W-1:0]    side_q [DATA_W];

  for (genvar s = 0; s < DATA_W; s++) begin : g_step
    logic                 v_in;
    logic [DATA_W-1:0]    work_in;
    logic [SIZE_BITS-1:0] rem_in;
    logic [SIDE_W-1:0]    side_in;
    logic [SIZE_BITS:0]   trial;
    logic [SIZE_BITS:0]   diff;
    logic                 qbit;
    logic [SIZE_BITS-1:0] rem_d;
    logic [DATA_W-1:0]    work_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign work_in = dividend_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign work_in = work_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, work_in[DATA_W-1]};
    assign diff  = trial - {1'b0, divisor_i};

    always_comb begin
      if (divisor_i == '0) begin
        qbit  = work_in[DATA_W-1];
        rem_d = '0;
      end else if (trial >= {1'b0, divisor_i}) begin
        qbit  = 1'b1;
        rem_d = diff[SIZE_BITS-1:0];
      end else begin
        qbit  = 1'b0;
        rem_d = trial[SIZE_BITS-1:0];
      end
    end

    assign work_d = {work_in[DATA_W-2:0], qbit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      work_q[s] <= work_d;
      rem_q[s]  <= rem_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o     = v_q[DATA_W-1];
  assign quotient_o  = work_q[DATA_W-1];
  assign remainder_o = rem_q[DATA_W-1];
  assign side_o      = side_q[DATA_W-1];

endmodule

>>> design/strided_concat_address_generator.sv
// ----------------------------------------------------------------------------
// strided_concat_address_generator
// Maps a flat source index to its strided source offset and its flat index
// in the concatenated destination; the element value rides along.
// ----------------------------------------------------------------------------
// The block takes one element on every cycle that start_i is high (busy_o is
// never raised) and returns each result on done_o, one result per cycle, in
// order. The index split gives each dimension its own 32-stage bit-serial
// divider; it is followed by an entry register, a multiply stage and an add
// stage per dimension for the address sums, and one output register.
// The receiver cannot stall, so results must be taken in the cycle that done_o
// is high. Configuration writes are always ready and must only be issued while
// no element is in flight.
// ----------------------------------------------------------------------------
module strided_concat_address_generator
  import scag_pkg::*;
#(
  parameter int MAX_DIMS  = DEF_MAX_DIMS,
  parameter int SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [DATA_W-1:0]    element_index_i,
  input  logic [DATA_W-1:0]    element_value_i,
  output logic                 done_o,
  output logic [DATA_W-1:0]    source_offset_o,
  output logic [DATA_W-1:0]    dest_index_o,
  output logic [DATA_W-1:0]    value_out_o,
  output logic                 index_beyond_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  localparam int ND_W   = $clog2(MAX_DIMS + 1);
  localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SIDE_W = DATA_W + MAX_DIMS * SIZE_BITS;
  localparam int CSH_W  = SHIFT_W + 1;

  typedef logic [MAX_DIMS-1:0][SIZE_BITS-1:0] coords_t;

  typedef struct packed {
    logic              beyond;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] dst;
    logic [DATA_W-1:0] val;
    coords_t           coords;
  } acc_t;

  typedef struct packed {
    acc_t              base;
    logic              act;
    logic [DATA_W-1:0] prod_d;
    logic [DATA_W-1:0] prod_s;
    logic [CSH_W-1:0]  csh;
  } mul_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIMS_W-1:0]   dims_q;
  logic [CONCAT_W-1:0] concat_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [DATA_W-1:0]   base_q;
  logic [WORD_W-1:0]   src_sizes_q;
  logic [WORD_W-1:0]   src_steps_q;
  logic [WORD_W-1:0]   dst_sizes_q;
  logic                cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q      <= DIMS_W'(1);
      concat_q    <= '0;
      shift_q     <= '0;
      base_q      <= '0;
      src_sizes_q <= '0;
      src_steps_q <= '0;
      dst_sizes_q <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DIMS_IN_USE:  dims_q      <= cfg_data_i[DIMS_W-1:0];
        REG_CONCAT_DIM:   concat_q    <= cfg_data_i[CONCAT_W-1:0];
        REG_DIM_SHIFT:    shift_q     <= cfg_data_i[SHIFT_W-1:0];
        REG_SOURCE_BASE:  base_q      <= cfg_data_i[DATA_W-1:0];
        REG_SOURCE_SIZES: src_sizes_q <= cfg_data_i;
        REG_SOURCE_STEPS: src_steps_q <= cfg_data_i;
        REG_DEST_SIZES:   dst_sizes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the dimension count to 1..MAX_DIMS
  logic [ND_W-1:0] nd;

  always_comb begin
    if (dims_q == '0) begin
      nd = ND_W'(1);
    end else if ({1'b0, dims_q} > 4'(MAX_DIMS)) begin
      nd = ND_W'(MAX_DIMS);
    end else begin
      nd = ND_W'(dims_q);
    end
  end

  // Unpack per-dimension fields; fields past bit 63 read as zero
  logic [SIZE_BITS-1:0] size_f  [MAX_DIMS];
  logic [SIZE_BITS-1:0] step_f  [MAX_DIMS];
  logic [SIZE_BITS-1:0] dsize_f [MAX_DIMS];

  always_comb begin
    logic [WORD_W-1:0] sz_w;
    logic [WORD_W-1:0] st_w;
    logic [WORD_W-1:0] ds_w;
    for (int d = 0; d < MAX_DIMS; d++) begin
      sz_w       = src_sizes_q >> (d * SIZE_BITS);
      st_w       = src_steps_q >> (d * SIZE_BITS);
      ds_w       = dst_sizes_q >> (d * SIZE_BITS);
      size_f[d]  = sz_w[SIZE_BITS-1:0];
      step_f[d]  = st_w[SIZE_BITS-1:0];
      dsize_f[d] = ds_w[SIZE_BITS-1:0];
    end
  end

  // Any source size of a dimension in use at zero makes the element count 0
  logic zero_hit;

  always_comb begin
    zero_hit = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (ND_W'(d) < nd && size_f[d] == '0) begin
        zero_hit = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Index split: slot k divides by the size of dimension nd-1-k
  // --------------------------------------------------------------------------
  assign busy_o = 1'b0;

  logic                 slot_v    [MAX_DIMS];
  logic [DATA_W-1:0]    slot_quo  [MAX_DIMS];
  logic [SIZE_BITS-1:0] slot_rem  [MAX_DIMS];
  logic [SIDE_W-1:0]    slot_side [MAX_DIMS];
  logic [SIDE_W-1:0]    side_in   [MAX_DIMS+1];

  assign side_in[0] = {{(MAX_DIMS * SIZE_BITS){1'b0}}, element_value_i};

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_slot
    logic                 slot_act;
    logic [DIDX_W-1:0]    slot_dim;
    logic [SIZE_BITS-1:0] divisor;
    logic                 v_in;
    logic [DATA_W-1:0]    dividend;

    assign slot_act = nd > ND_W'(k);
    assign slot_dim = DIDX_W'(nd - ND_W'(k + 1));
    assign divisor  = slot_act ? size_f[slot_dim] : '0;

    if (k == 0) begin : g_head
      assign v_in     = start_i & ~busy_o;
      assign dividend = element_index_i;
    end else begin : g_chain
      assign v_in     = slot_v[k-1];
      assign dividend = slot_quo[k-1];
    end

    scag_div_slot #(
      .SIZE_BITS (SIZE_BITS),
      .SIDE_W    (SIDE_W)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (v_in),
      .dividend_i  (dividend),
      .divisor_i   (divisor),
      .side_i      (side_in[k]),
      .valid_o     (slot_v[k]),
      .quotient_o  (slot_quo[k]),
      .remainder_o (slot_rem[k]),
      .side_o      (slot_side[k])
    );

    // Drop the remainder into this slot's coordinate field
    always_comb begin
      side_in[k+1] = slot_side[k];
      side_in[k+1][DATA_W + k * SIZE_BITS +: SIZE_BITS] = slot_rem[k];
    end
  end

  // --------------------------------------------------------------------------
  // Entry stage: a leftover quotient means the index is past the element count
  // --------------------------------------------------------------------------
  logic ent_v_q;
  acc_t ent_d;
  acc_t ent_q;

  always_comb begin
    ent_d.beyond = (slot_quo[MAX_DIMS-1] != '0) || zero_hit;
    ent_d.src    = base_q;
    ent_d.dst    = '0;
    ent_d.val    = side_in[MAX_DIMS][DATA_W-1:0];
    ent_d.coords = side_in[MAX_DIMS][SIDE_W-1:DATA_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else begin
      ent_v_q <= slot_v[MAX_DIMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // --------------------------------------------------------------------------
  // Address sums: step j handles dimension j + nd - MAX_DIMS, coordinate of
  // slot MAX_DIMS-1-j; a multiply stage then an add stage
  // --------------------------------------------------------------------------
  logic mul_v_q [MAX_DIMS];
  mul_t mul_q   [MAX_DIMS];
  logic add_v_q [MAX_DIMS];
  acc_t add_q   [MAX_DIMS];

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_mac
    logic                        v_in;
    acc_t                        prev;
    logic                        mac_act;
    logic [DIDX_W-1:0]           mac_dim;
    logic [SIZE_BITS-1:0]        coord;
    logic                        is_concat;
    logic [DATA_W+SIZE_BITS-1:0] pd_full;
    logic [2*SIZE_BITS-1:0]      ps_full;
    mul_t                        mul_d;
    acc_t                        add_d;

    if (j == 0) begin : g_head
      assign v_in = ent_v_q;
      assign prev = ent_q;
    end else begin : g_chain
      assign v_in = add_v_q[j-1];
      assign prev = add_q[j-1];
    end

    assign mac_act   = nd >= ND_W'(MAX_DIMS - j);
    assign mac_dim   = DIDX_W'(nd - ND_W'(MAX_DIMS - j));
    assign coord     = prev.coords[MAX_DIMS-1-j];
    assign is_concat = 4'(mac_dim) == 4'(concat_q);
    assign pd_full   = {{SIZE_BITS{1'b0}}, prev.dst} *
                       {{DATA_W{1'b0}}, dsize_f[mac_dim]};
    assign ps_full   = {{SIZE_BITS{1'b0}}, coord} *
                       {{SIZE_BITS{1'b0}}, step_f[mac_dim]};

    always_comb begin
      mul_d.base   = prev;
      mul_d.act    = mac_act;
      mul_d.prod_d = pd_full[DATA_W-1:0];
      mul_d.prod_s = DATA_W'(ps_full);
      mul_d.csh    = CSH_W'(coord) + (is_concat ? CSH_W'(shift_q) : CSH_W'(0));
    end

    always_comb begin
      add_d = mul_q[j].base;
      if (mul_q[j].act) begin
        add_d.dst = mul_q[j].prod_d + DATA_W'(mul_q[j].csh);
        add_d.src = mul_q[j].base.src + mul_q[j].prod_s;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_v_q[j] <= 1'b0;
        add_v_q[j] <= 1'b0;
      end else begin
        mul_v_q[j] <= v_in;
        add_v_q[j] <= mul_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      mul_q[j] <= mul_d;
      add_q[j] <= add_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: zero both addresses for an out-of-range index
  // --------------------------------------------------------------------------
  acc_t                fin;
  logic                done_q;
  logic [DATA_W-1:0]   src_out_q;
  logic [DATA_W-1:0]   dst_out_q;
  logic [DATA_W-1:0]   val_out_q;
  logic                beyond_q;

  assign fin = add_q[MAX_DIMS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= add_v_q[MAX_DIMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    src_out_q <= fin.beyond ? '0 : fin.src;
    dst_out_q <= fin.beyond ? '0 : fin.dst;
    val_out_q <= fin.val;
    beyond_q  <= fin.beyond;
  end

  assign done_o          = done_q;
  assign source_offset_o = src_out_q;
  assign dest_index_o    = dst_out_q;
  assign value_out_o     = val_out_q;
  assign index_beyond_o  = beyond_q;

`ifndef SYNTHESIS
  a_beyond_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && index_beyond_o |-> source_offset_o == '0 && dest_index_o == '0)
    else $error("out-of-range result carries a nonzero address");

  a_zero_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_hit |-> index_beyond_o)
    else $error("zero source size did not flag the result");

  a_tail_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_v[MAX_DIMS-1] |-> ##(2*MAX_DIMS+2) done_o)
    else $error("split result lost in the address-sum stages");
`endif

endmodule
